// ----- rtl/dagf_pkg.sv -----
// ---------------------------------------------------------------------------
// DAG addable-edge finder package
// Shared codes, controller states and the command and status bundles.
// ---------------------------------------------------------------------------
package dagf_pkg;

    localparam int VERTEX_W    = 6;
    localparam int MASK_W      = 64;
    localparam int CFG_W       = 7;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 72;
    localparam logic [CFG_W-1:0] VCOUNT_RESET = 7'd64;

    // Operation codes carried in tuser of the input stream.
    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_SOLVE = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    // Datapath operations issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_ADD_RD,
        OP_ADD_WR,
        OP_ROOT_SKIP,
        OP_ROOT_OPEN,
        OP_DEG_RD,
        OP_DEG_LATCH,
        OP_ADJ_RD,
        OP_PUSH,
        OP_POP,
        OP_POP_LATCH,
        OP_E_TOPO_RD,
        OP_E_VERTEX,
        OP_E_ACC,
        OP_E_LOAD
    } t_op;

    typedef struct packed {
        t_op  op;
        logic out_next;
    } t_cmd;

    typedef struct packed {
        logic root_done;
        logic root_visited;
        logic has_next;
        logic sp_one;
        logic push_ok;
        logic emit_done;
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_ROOT,
        S_DEG_RD,
        S_DEG_W,
        S_STEP,
        S_ADJ_W,
        S_POP_W,
        S_E_TOPO,
        S_E_TW,
        S_E_DW,
        S_E_ADJ,
        S_E_AW,
        S_E_OUT
    } t_state;

endpackage

// ----- rtl/dagf_ctrl.sv -----
// ---------------------------------------------------------------------------
// DAG addable-edge finder controller
// Sequences edge loading, the depth-first walk and the result emission.
// ---------------------------------------------------------------------------
module dagf_ctrl
    import dagf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  t_func   i_in_func,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_func)
                        FUNC_ADD:   n_state = S_ADD_RD;
                        FUNC_SOLVE: n_state = S_ROOT;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_RD: n_state = S_ADD_WR;
            S_ADD_WR: n_state = S_IDLE;
            S_ROOT: begin
                if (i_status.root_done) begin
                    n_state = S_E_TOPO;
                end else if (!i_status.root_visited) begin
                    n_state = S_DEG_RD;
                end
            end
            S_DEG_RD: n_state = S_DEG_W;
            S_DEG_W:  n_state = S_STEP;
            S_STEP: begin
                if (i_status.has_next) begin
                    n_state = S_ADJ_W;
                end else if (i_status.sp_one) begin
                    n_state = S_ROOT;
                end else begin
                    n_state = S_POP_W;
                end
            end
            S_ADJ_W:  n_state = i_status.push_ok ? S_DEG_RD : S_STEP;
            S_POP_W:  n_state = S_DEG_RD;
            S_E_TOPO: n_state = i_status.emit_done ? S_IDLE : S_E_TW;
            S_E_TW:   n_state = S_E_DW;
            S_E_DW:   n_state = S_E_ADJ;
            S_E_ADJ:  n_state = i_status.has_next ? S_E_AW : S_E_OUT;
            S_E_AW:   n_state = S_E_ADJ;
            S_E_OUT: begin
                if (i_out_ready) begin
                    n_state = S_E_TOPO;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Output logic: handshakes and datapath commands.
    always_comb begin
        o_in_ready      = 1'b0;
        o_out_valid     = 1'b0;
        o_cmd.op        = OP_NONE;
        o_cmd.out_next  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                end
            end
            S_ADD_RD: o_cmd.op = OP_ADD_RD;
            S_ADD_WR: o_cmd.op = OP_ADD_WR;
            S_ROOT: begin
                if (!i_status.root_done) begin
                    o_cmd.op = i_status.root_visited ? OP_ROOT_SKIP : OP_ROOT_OPEN;
                end
            end
            S_DEG_RD: o_cmd.op = OP_DEG_RD;
            S_DEG_W:  o_cmd.op = OP_DEG_LATCH;
            S_STEP:   o_cmd.op = i_status.has_next ? OP_ADJ_RD : OP_POP;
            S_ADJ_W: begin
                if (i_status.push_ok) begin
                    o_cmd.op = OP_PUSH;
                end
            end
            S_POP_W: o_cmd.op = OP_POP_LATCH;
            S_E_TOPO: begin
                if (!i_status.emit_done) begin
                    o_cmd.op = OP_E_TOPO_RD;
                end
            end
            S_E_TW:  o_cmd.op = OP_E_VERTEX;
            S_E_DW:  o_cmd.op = OP_DEG_LATCH;
            S_E_ADJ: o_cmd.op = i_status.has_next ? OP_ADJ_RD : OP_E_LOAD;
            S_E_AW:  o_cmd.op = OP_E_ACC;
            S_E_OUT: begin
                o_out_valid    = 1'b1;
                o_cmd.out_next = i_out_ready;
            end
            default: o_cmd.op = OP_NONE;
        endcase
    end

endmodule

// ----- rtl/dagf_datapath.sv -----
// ---------------------------------------------------------------------------
// DAG addable-edge finder datapath
// Adjacency, degree, walk stack and order memories with the walk registers.
// ---------------------------------------------------------------------------
module dagf_datapath
    import dagf_pkg::*;
#(
    parameter int MAX_VERTICES   = 64,
    parameter int MAX_OUT_DEGREE = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  t_func               i_func,
    input  logic [VERTEX_W-1:0] i_from,
    input  logic [VERTEX_W-1:0] i_to,
    input  logic [CFG_W-1:0]    i_nv,
    output t_status             o_status,
    output logic [VERTEX_W-1:0] o_src,
    output logic [MASK_W-1:0]   o_mask,
    output logic                o_ovf,
    output logic                o_last
);

    localparam int VW        = $clog2(MAX_VERTICES);
    localparam int CW        = $clog2(MAX_VERTICES + 1);
    localparam int DW        = $clog2(MAX_OUT_DEGREE + 1);
    localparam int ADJ_DEPTH = MAX_VERTICES * MAX_OUT_DEGREE;
    localparam int AW        = (ADJ_DEPTH > 1) ? $clog2(ADJ_DEPTH) : 1;
    localparam int SW        = VERTEX_W + DW;

    // Memories.
    logic [VERTEX_W-1:0] m_adj  [ADJ_DEPTH];
    logic [DW-1:0]       m_deg  [MAX_VERTICES];
    logic [SW-1:0]       m_stk  [MAX_VERTICES];
    logic [VERTEX_W-1:0] m_topo [MAX_VERTICES];

    // Control registers.
    logic [MAX_VERTICES-1:0] r_deg_vld;
    logic                    r_ovf;
    logic [CW-1:0]           r_sp;
    logic [CW-1:0]           r_count;
    logic [CW-1:0]           r_p;
    logic [CFG_W-1:0]        r_root;

    // Payload registers.
    logic [VERTEX_W-1:0] r_from, r_to, r_cur_v;
    logic [DW-1:0]       r_cur_next, r_cur_deg;
    logic [MASK_W-1:0]   r_vis, r_seen, r_succ, r_o_mask;
    logic [VERTEX_W-1:0] r_o_src;
    logic                r_o_last;
    logic [VERTEX_W-1:0] r_adj_rd, r_topo_rd;
    logic [DW-1:0]       r_deg_rd;
    logic                r_deg_rd_vld;
    logic [SW-1:0]       r_stk_rd;

    logic [DW-1:0]       deg_q;
    logic [VW-1:0]       deg_addr;
    logic [AW-1:0]       adj_rd_addr;
    logic [AW-1:0]       adj_wr_addr;
    logic                add_bad;
    logic                w_in_range;
    logic [MASK_W-1:0]   all_mask;
    logic [MASK_W-1:0]   cur_bit;
    logic [MASK_W-1:0]   seen_next;

    function automatic logic [AW-1:0] adj_addr(input logic [VERTEX_W-1:0] v,
                                               input logic [DW-1:0] k);
        logic [13:0] full;
        full = 14'(v) * 14'(MAX_OUT_DEGREE) + 14'(k);
        return full[AW-1:0];
    endfunction

    // Address and flag logic.
    assign deg_q       = r_deg_rd_vld ? r_deg_rd : '0;
    assign adj_rd_addr = adj_addr(r_cur_v, r_cur_next);
    assign adj_wr_addr = adj_addr(r_from, deg_q);
    assign add_bad     = ({1'b0, r_from} >= i_nv) || ({1'b0, r_to} >= i_nv) ||
                         (deg_q == DW'(MAX_OUT_DEGREE));
    assign w_in_range  = {1'b0, r_adj_rd} < i_nv;
    assign cur_bit     = MASK_W'(1) << r_cur_v;
    assign seen_next   = r_seen | cur_bit;

    always_comb begin
        case (i_cmd.op)
            OP_ADD_RD:   deg_addr = r_from[VW-1:0];
            OP_E_VERTEX: deg_addr = r_topo_rd[VW-1:0];
            default:     deg_addr = r_cur_v[VW-1:0];
        endcase
    end

    // Vertices below the live count.
    always_comb begin
        for (int i = 0; i < MASK_W; i++) begin
            all_mask[i] = CFG_W'(i) < i_nv;
        end
    end

    // Status to the controller.
    assign o_status.root_done    = r_root >= i_nv;
    assign o_status.root_visited = r_vis[r_root[VERTEX_W-1:0]];
    assign o_status.has_next     = r_cur_next < r_cur_deg;
    assign o_status.sp_one       = r_sp == CW'(1);
    assign o_status.push_ok      = w_in_range && !r_vis[r_adj_rd] &&
                                   (r_sp < CW'(MAX_VERTICES));
    assign o_status.emit_done    = r_p == r_count;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg_vld <= '0;
            r_ovf     <= 1'b0;
            r_sp      <= '0;
            r_count   <= '0;
            r_p       <= '0;
            r_root    <= '0;
        end else begin
            case (i_cmd.op)
                OP_ACCEPT: begin
                    case (i_func)
                        FUNC_SOLVE: begin
                            r_sp    <= '0;
                            r_count <= '0;
                            r_p     <= '0;
                            r_root  <= '0;
                        end
                        FUNC_CLEAR: begin
                            r_deg_vld <= '0;
                            r_ovf     <= 1'b0;
                        end
                        default: ;
                    endcase
                end
                OP_ADD_WR: begin
                    if (add_bad) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_deg_vld[r_from[VW-1:0]] <= 1'b1;
                    end
                end
                OP_ROOT_SKIP: r_root <= r_root + CFG_W'(1);
                OP_ROOT_OPEN: r_sp <= CW'(1);
                OP_PUSH:      r_sp <= r_sp + CW'(1);
                OP_POP: begin
                    r_sp <= r_sp - CW'(1);
                    if (r_count < CW'(MAX_VERTICES)) begin
                        r_count <= r_count + CW'(1);
                    end
                    if (r_sp == CW'(1)) begin
                        r_root <= r_root + CFG_W'(1);
                    end
                end
                default: ;
            endcase
            if (i_cmd.out_next) begin
                r_p <= r_p + CW'(1);
            end
        end
    end

    // Walk and emission payload.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_ACCEPT: begin
                r_from <= i_from;
                r_to   <= i_to;
                if (i_func == FUNC_SOLVE) begin
                    r_vis  <= '0;
                    r_seen <= '0;
                end
            end
            OP_ROOT_OPEN: begin
                r_vis[r_root[VERTEX_W-1:0]] <= 1'b1;
                r_cur_v    <= r_root[VERTEX_W-1:0];
                r_cur_next <= '0;
            end
            OP_DEG_LATCH: r_cur_deg <= deg_q;
            OP_ADJ_RD:    r_cur_next <= r_cur_next + DW'(1);
            OP_PUSH: begin
                r_vis[r_adj_rd] <= 1'b1;
                r_cur_v    <= r_adj_rd;
                r_cur_next <= '0;
            end
            OP_POP_LATCH: {r_cur_v, r_cur_next} <= r_stk_rd;
            OP_E_VERTEX: begin
                r_cur_v    <= r_topo_rd;
                r_cur_next <= '0;
                r_succ     <= '0;
            end
            OP_E_ACC: begin
                if (w_in_range) begin
                    r_succ <= r_succ | (MASK_W'(1) << r_adj_rd);
                end
            end
            OP_E_LOAD: begin
                r_o_src  <= r_cur_v;
                r_o_mask <= all_mask & ~seen_next & ~r_succ;
                r_o_last <= (r_p + CW'(1)) == r_count;
                r_seen   <= seen_next;
            end
            default: ;
        endcase
    end

    // Memory writes.
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_ADD_WR && !add_bad) begin
            m_adj[adj_wr_addr]     <= r_to;
            m_deg[r_from[VW-1:0]]  <= deg_q + DW'(1);
        end
        if (i_cmd.op == OP_PUSH) begin
            m_stk[VW'(r_sp - CW'(1))] <= {r_cur_v, r_cur_next};
        end
        if (i_cmd.op == OP_POP && r_count < CW'(MAX_VERTICES)) begin
            m_topo[r_count[VW-1:0]] <= r_cur_v;
        end
    end

    // Registered memory reads.
    always_ff @(posedge i_clk) begin
        r_adj_rd     <= m_adj[adj_rd_addr];
        r_deg_rd     <= m_deg[deg_addr];
        r_deg_rd_vld <= r_deg_vld[deg_addr];
        r_stk_rd     <= m_stk[VW'(r_sp - CW'(2))];
        r_topo_rd    <= m_topo[VW'(r_count - CW'(1) - r_p)];
    end

    assign o_src  = r_o_src;
    assign o_mask = r_o_mask;
    assign o_ovf  = r_ovf;
    assign o_last = r_o_last;

endmodule

// ----- rtl/dag_addable_edge_finder_unit.sv -----
// ---------------------------------------------------------------------------
// DAG addable-edge finder
// Holds a directed graph and, on request, emits its topological order with
// the mask of edges that may be added from each vertex.
// ---------------------------------------------------------------------------
// Input stream: tuser selects add edge, solve or clear; tdata holds the
// edge endpoints. Neither an add nor a clear gives an output transaction.
// A solve runs a depth-first walk from each unvisited root; the parent's
// degree is read again on return from a vertex reached through an edge.
// It then emits one output transaction per vertex. One input transaction
// is worked on at a time; tready stays low until it is done. tlast marks
// the final vertex of the order. A stalled receiver holds the emission at
// the current result, which stays stable until taken.
// The configuration channel sets the vertex count and is always ready;
// write it only while the block is idle. Reset empties the graph, clears
// the overflow flag and sets the vertex count to 64.
// ---------------------------------------------------------------------------
module dag_addable_edge_finder_unit
    import dagf_pkg::*;
#(
    parameter int MAX_VERTICES   = 64,
    parameter int MAX_OUT_DEGREE = 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_W-1:0]       i_cfg_data,       // vertex_count
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,   // from_vertex, to_vertex
    input  logic [1:0]             i_s_axis_tuser,   // func
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,   // source_vertex, addable_mask, overflow
    output logic                   o_m_axis_tlast
);

    logic [CFG_W-1:0]    r_vertex_count;
    logic [CFG_W-1:0]    nv;
    t_func               in_func;
    t_cmd                cmd;
    t_status             status;
    logic [VERTEX_W-1:0] src;
    logic [MASK_W-1:0]   mask;
    logic                ovf;

    // Configuration register.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VCOUNT_RESET;
        end else if (i_cfg_valid) begin
            r_vertex_count <= i_cfg_data;
        end
    end

    // Live vertex count, clamped to the supported range.
    always_comb begin
        if (r_vertex_count == '0) begin
            nv = CFG_W'(1);
        end else if (r_vertex_count > CFG_W'(MAX_VERTICES)) begin
            nv = CFG_W'(MAX_VERTICES);
        end else begin
            nv = r_vertex_count;
        end
    end

    assign in_func = t_func'(i_s_axis_tuser);

    dagf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .i_in_func   (in_func),
        .i_out_ready (i_m_axis_tready),
        .i_status    (status),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd)
    );

    dagf_datapath #(
        .MAX_VERTICES   (MAX_VERTICES),
        .MAX_OUT_DEGREE (MAX_OUT_DEGREE)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_func   (in_func),
        .i_from   (i_s_axis_tdata[5:0]),
        .i_to     (i_s_axis_tdata[11:6]),
        .i_nv     (nv),
        .o_status (status),
        .o_src    (src),
        .o_mask   (mask),
        .o_ovf    (ovf),
        .o_last   (o_m_axis_tlast)
    );

    // Output packing, lowest field first.
    assign o_m_axis_tdata = {1'b0, ovf, mask, src};

endmodule
